### design/utf8d_pkg.sv
package utf8d_pkg;

    localparam int CP_W    = 21;
    localparam int LEN_W   = 3;
    localparam int BITS_W  = 7;
    localparam int QDEPTH  = 2;
    localparam int QIDX_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // class of one raw byte as seen by the front
    typedef enum logic [2:0] {
        K_ASCII,
        K_LEAD2,
        K_LEAD3,
        K_LEAD4,
        K_CONT,
        K_BAD
    } t_byte_kind;

    // classified byte: kind plus the value bits it contributes
    typedef struct packed {
        t_byte_kind          kind;
        logic [BITS_W-1:0]   bits;
    } t_cls_item;

    typedef struct packed {
        logic       en;
        t_cls_item  item;
    } t_q_wr;

    typedef struct packed {
        logic       valid;
        t_cls_item  item;
    } t_q_rd;

endpackage

### design/utf8d_front.sv
module utf8d_front (
    input  logic              i_push,
    input  logic [7:0]        i_byte,
    input  logic              i_q_full,
    output logic              o_full,
    output utf8d_pkg::t_q_wr  o_wr
);

    utf8d_pkg::t_cls_item cls;

    always_comb begin
        cls.kind = utf8d_pkg::K_BAD;
        cls.bits = '0;
        unique case (i_byte) inside
            8'b0???????: begin
                cls.kind = utf8d_pkg::K_ASCII;
                cls.bits = i_byte[6:0];
            end
            8'b10??????: begin
                cls.kind = utf8d_pkg::K_CONT;
                cls.bits = {1'b0, i_byte[5:0]};
            end
            8'b110?????: begin
                cls.kind = utf8d_pkg::K_LEAD2;
                cls.bits = {2'b00, i_byte[4:0]};
            end
            8'b1110????: begin
                cls.kind = utf8d_pkg::K_LEAD3;
                cls.bits = {3'b000, i_byte[3:0]};
            end
            8'b11110???: begin
                cls.kind = utf8d_pkg::K_LEAD4;
                cls.bits = {4'b0000, i_byte[2:0]};
            end
            default: begin
                cls.kind = utf8d_pkg::K_BAD;
                cls.bits = '0;
            end
        endcase
    end

    assign o_full    = i_q_full;
    assign o_wr.en   = i_push && !i_q_full;
    assign o_wr.item = cls;

endmodule

### design/utf8d_queue.sv
module utf8d_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  utf8d_pkg::t_q_wr  i_wr,
    input  logic              i_rd,
    output logic              o_full,
    output utf8d_pkg::t_q_rd  o_rd
);

    utf8d_pkg::t_cls_item                 r_mem [utf8d_pkg::QDEPTH];
    logic [utf8d_pkg::QIDX_W-1:0]         r_wptr, n_wptr;
    logic [utf8d_pkg::QIDX_W-1:0]         r_rptr, n_rptr;
    logic [utf8d_pkg::QCNT_W-1:0]         r_cnt, n_cnt;
    logic                                 do_rd;

    localparam logic [utf8d_pkg::QIDX_W-1:0] LAST_IDX =
        utf8d_pkg::QIDX_W'(utf8d_pkg::QDEPTH - 1);
    localparam logic [utf8d_pkg::QCNT_W-1:0] FULL_CNT =
        utf8d_pkg::QCNT_W'(utf8d_pkg::QDEPTH);

    assign do_rd = i_rd && (r_cnt != '0);

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_wr.en) begin
            n_wptr = (r_wptr == LAST_IDX) ? '0 : r_wptr + 1'b1;
        end
        if (do_rd) begin
            n_rptr = (r_rptr == LAST_IDX) ? '0 : r_rptr + 1'b1;
        end
        if (i_wr.en && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr.en && do_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[r_wptr] <= i_wr.item;
        end
    end

    assign o_full     = (r_cnt == FULL_CNT);
    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.item  = r_mem[r_rptr];

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> (r_cnt != FULL_CNT))
        else $error("write into full queue");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.en && !do_rd) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow write");

endmodule

### design/utf8d_back.sv
module utf8d_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  utf8d_pkg::t_q_rd              i_rd,
    output logic                          o_rd,
    input  logic                          i_pop,
    output logic                          o_valid,
    output logic [utf8d_pkg::CP_W-1:0]    o_scalar,
    output logic [utf8d_pkg::LEN_W-1:0]   o_seq_len
);

    logic [1:0]                       r_left, n_left;
    logic [utf8d_pkg::CP_W-1:0]       r_acc, n_acc;
    logic [utf8d_pkg::LEN_W-1:0]      r_len, n_len;
    logic                             r_out_valid, n_out_valid;
    logic [utf8d_pkg::CP_W-1:0]       r_cp, n_cp;
    logic [utf8d_pkg::LEN_W-1:0]      r_slen, n_slen;
    logic                             take;
    logic [utf8d_pkg::CP_W-1:0]       shifted;

    // output register frees up when empty or being popped this cycle
    assign take    = i_rd.valid && (!r_out_valid || i_pop);
    assign o_rd    = take;
    assign shifted = {r_acc[utf8d_pkg::CP_W-7:0], i_rd.item.bits[5:0]};

    always_comb begin
        n_left      = r_left;
        n_acc       = r_acc;
        n_len       = r_len;
        n_out_valid = r_out_valid && !i_pop;
        n_cp        = r_cp;
        n_slen      = r_slen;
        if (take) begin
            if (r_left != 2'd0) begin
                if (i_rd.item.kind != utf8d_pkg::K_CONT) begin
                    // abort, byte dropped
                    n_left = 2'd0;
                    n_acc  = '0;
                    n_len  = '0;
                end else if (r_left == 2'd1) begin
                    n_out_valid = 1'b1;
                    n_cp        = shifted;
                    n_slen      = r_len;
                    n_left      = 2'd0;
                    n_acc       = '0;
                    n_len       = '0;
                end else begin
                    n_acc  = shifted;
                    n_left = r_left - 2'd1;
                end
            end else begin
                case (i_rd.item.kind)
                    utf8d_pkg::K_ASCII: begin
                        n_out_valid = 1'b1;
                        n_cp        = utf8d_pkg::CP_W'(i_rd.item.bits);
                        n_slen      = utf8d_pkg::LEN_W'(1);
                    end
                    utf8d_pkg::K_LEAD2: begin
                        n_acc  = utf8d_pkg::CP_W'(i_rd.item.bits);
                        n_left = 2'd1;
                        n_len  = utf8d_pkg::LEN_W'(2);
                    end
                    utf8d_pkg::K_LEAD3: begin
                        n_acc  = utf8d_pkg::CP_W'(i_rd.item.bits);
                        n_left = 2'd2;
                        n_len  = utf8d_pkg::LEN_W'(3);
                    end
                    utf8d_pkg::K_LEAD4: begin
                        n_acc  = utf8d_pkg::CP_W'(i_rd.item.bits);
                        n_left = 2'd3;
                        n_len  = utf8d_pkg::LEN_W'(4);
                    end
                    default: begin
                        // stray continuation or invalid byte: dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= 2'd0;
            r_acc       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_left      <= n_left;
            r_acc       <= n_acc;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp   <= n_cp;
        r_slen <= n_slen;
    end

    assign o_valid   = r_out_valid;
    assign o_scalar  = r_cp;
    assign o_seq_len = r_slen;

    a_closed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left == 2'd0) |-> (r_len == '0 && r_acc == '0))
        else $error("closed sequence left stale state");

    a_open_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != 2'd0) |-> (r_len > {1'b0, r_left} && r_len <= 3'd4))
        else $error("open length inconsistent with bytes left");

    a_ascii_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_slen == 3'd1) |-> (r_cp[utf8d_pkg::CP_W-1:7] == '0))
        else $error("one-byte result wider than seven bits");

    a_out_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_slen != 3'd0 && r_slen <= 3'd4))
        else $error("result length out of range");

endmodule

### design/utf8_stream_decoder_unit.sv
// utf8 stream decoder: one raw byte in per transaction, one code point out
// per completed sequence
//
// input side looks like a queue: drive i_in_byte and push; the byte is taken
// at a clock edge where push is high and full is low
// output side looks like a queue too: while empty is low the oldest code
// point and its sequence length are on o_scalar / o_seq_len, and pop
// high at a clock edge takes it
//
// throughput: one byte per cycle sustained while the output register is empty
// or popped, limited only by the single accumulator update in the back end
// path: a byte that completes a sequence goes into the byte queue at its push
// edge, then into the output register when the back end takes it
// bytes that open or extend a sequence, or get dropped, give no result
//
// reset (i_rst_n low, synchronous) empties the byte queue and output
// register and closes any open sequence
// if the receiver stalls, the output register holds, the back end stops
// draining the two-entry byte queue, and full rises once it fills
module utf8_stream_decoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input transaction
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_in_byte,
    // result transaction
    output logic                          empty,
    input  logic                          pop,
    output logic [utf8d_pkg::CP_W-1:0]    o_scalar,
    output logic [utf8d_pkg::LEN_W-1:0]   o_seq_len
);

    utf8d_pkg::t_q_wr  q_wr;
    utf8d_pkg::t_q_rd  q_rd;
    logic              q_full;
    logic              q_rd_en;
    logic              out_valid;

    // front: classify each accepted byte into kind plus value bits
    utf8d_front u_front (
        .i_push   (push),
        .i_byte   (i_in_byte),
        .i_q_full (q_full),
        .o_full   (full),
        .o_wr     (q_wr)
    );

    // short queue decoupling classification from sequence assembly
    utf8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_rd    (q_rd_en),
        .o_full  (q_full),
        .o_rd    (q_rd)
    );

    // back: sequence state machine plus the output register
    utf8d_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (q_rd),
        .o_rd      (q_rd_en),
        .i_pop     (pop),
        .o_valid   (out_valid),
        .o_scalar  (o_scalar),
        .o_seq_len (o_seq_len)
    );

    assign empty = !out_valid;

endmodule
